// ----- rtl/core/hsvrgb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, constants and types of the hsv to rgb color converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   // field widths
   localparam int unsigned HUE_W   = 10;
   localparam int unsigned PCT_W   = 7;
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned DEG_W   = 9;   // reduced hue 0..359
   localparam int unsigned FRAC_W  = 6;   // hue remainder 0..59
   localparam int unsigned REQ_W   = HUE_W + 2 * PCT_W;
   localparam int unsigned RSP_W   = 3 * LEVEL_W;

   // color constants
   localparam int unsigned DEG_TURN   = 360;
   localparam int unsigned DEG_SECTOR = 60;
   localparam int unsigned PCT_FULL   = 100;
   localparam int unsigned LEVEL_FULL = 255;
   localparam int unsigned SCALE_QT   = PCT_FULL * DEG_SECTOR;   // 6000

   // intermediate widths
   localparam int unsigned FULL_W = 15;   // value * 255, up to 25500
   localparam int unsigned COEF_W = 13;   // up to 6000
   localparam int unsigned NP_W   = 22;   // up to 2550000
   localparam int unsigned NQT_W  = 28;   // up to 153000000

   // constant divisors of the three channel candidates
   localparam int unsigned DIV_TOP = PCT_FULL;
   localparam int unsigned DIV_P   = PCT_FULL * PCT_FULL;
   localparam int unsigned DIV_QT  = PCT_FULL * PCT_FULL * DEG_SECTOR;

   // hue sector, 60 degrees each
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   // load enables of the two divider stages
   typedef struct packed {
      logic est;
      logic fix;
   } div_adv_type;

endpackage

// ----- rtl/core/hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts hue, saturation and value to 8-bit red, green and blue levels.
// ----------------------------------------------------------------------------
// Usage:
//   One color enters per transfer on the req_ stream and one rgb triple
//   leaves per transfer on the rsp_ stream, in order. Hue is any 10-bit
//   value and is reduced modulo 360; saturation and value above 100 clamp.
//   Pipeline: seven register stages, stages 1 to 6 and the output register
//   that drives rsp_tdata and rsp_tvalid.
//   Throughput: one color per clock cycle when nothing stalls, set by the
//   fully pipelined datapath (hue reduce, sector split, coefficients, products,
//   two constant-divider stages, channel select into the output register).
//   Stall: each stage holds while the one after it is full and not moving;
//   req_tready falls only when the pipeline is full behind a stalled rsp_.
//   Empty stages fill, so bubbles are squeezed out during a stall.
//   Reset: synchronous, clears all stage valid bits; rsp_tvalid goes low
//   and req_tready is high in the first cycle after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // hue[9:0], saturation[16:10], brightness[23:17]
   input  logic [hsvrgb_pkg::REQ_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   output logic [hsvrgb_pkg::RSP_W-1:0] rsp_tdata
);
   import hsvrgb_pkg::*;

   localparam int unsigned STAGES = 6;

   logic [HUE_W-1:0]   req_hue;
   logic [PCT_W-1:0]   req_sat;
   logic [PCT_W-1:0]   req_bri;

   logic [STAGES:1]    valid_ff;
   logic [STAGES:1]    rdy;
   logic               out_valid_ff;
   logic               out_rdy;

   // stage 1
   logic [DEG_W-1:0]   deg_in,  deg_ff;
   logic [PCT_W-1:0]   sat1_in, sat1_ff;
   logic [PCT_W-1:0]   val1_in, val1_ff;
   // stage 2
   sector_type         sec2_in, sec2_ff;
   logic [FRAC_W-1:0]  frac2_in, frac2_ff;
   logic [PCT_W-1:0]   sat2_ff;
   logic [FULL_W-1:0]  full2_in, full2_ff;
   // stage 3
   sector_type         sec3_ff;
   logic [FULL_W-1:0]  full3_ff;
   logic [PCT_W-1:0]   cp3_in, cp3_ff;
   logic [COEF_W-1:0]  cq3_in, cq3_ff;
   logic [COEF_W-1:0]  ct3_in, ct3_ff;
   logic [FRAC_W-1:0]  rest3;
   // stage 4
   sector_type         sec4_ff;
   logic [FULL_W-1:0]  full4_ff;
   logic [NP_W-1:0]    np4_in, np4_ff;
   logic [NQT_W-1:0]   nq4_in, nq4_ff;
   logic [NQT_W-1:0]   nt4_in, nt4_ff;
   // stages 5 and 6 (data inside the dividers)
   sector_type         sec5_ff, sec6_ff;
   div_adv_type        div_adv;
   logic [LEVEL_W-1:0] top_lv, p_lv, q_lv, t_lv;
   // output register
   logic [LEVEL_W-1:0] red_in, green_in, blue_in;
   logic [RSP_W-1:0]   rsp_in, rsp_ff;

   assign req_hue = req_tdata[HUE_W-1:0];
   assign req_sat = req_tdata[HUE_W +: PCT_W];
   assign req_bri = req_tdata[HUE_W + PCT_W +: PCT_W];

   // ready chain: a stage loads when it is empty or its content moves on
   assign out_rdy = !out_valid_ff || rsp_tready;
   always_comb begin
      rdy[STAGES] = !valid_ff[STAGES] || out_rdy;
      for (int i = STAGES - 1; i >= 1; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end
   assign req_tready = rdy[1];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy[1]) valid_ff[1] <= req_tvalid;
         for (int i = 2; i <= STAGES; i++) begin
            if (rdy[i]) valid_ff[i] <= valid_ff[i-1];
         end
         if (out_rdy) out_valid_ff <= valid_ff[STAGES];
      end
   end

   // stage 1: hue modulo 360, percentage clamps
   always_comb begin
      priority if (req_hue >= HUE_W'(2 * DEG_TURN)) begin
         deg_in = DEG_W'(req_hue - HUE_W'(2 * DEG_TURN));
      end else if (req_hue >= HUE_W'(DEG_TURN)) begin
         deg_in = DEG_W'(req_hue - HUE_W'(DEG_TURN));
      end else begin
         deg_in = DEG_W'(req_hue);
      end
   end
   assign sat1_in = (req_sat > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : req_sat;
   assign val1_in = (req_bri > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : req_bri;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         deg_ff  <= deg_in;
         sat1_ff <= sat1_in;
         val1_ff <= val1_in;
      end
   end

   // stage 2: sector and remainder, full scale value * 255
   always_comb begin
      priority if (deg_ff < DEG_W'(DEG_SECTOR)) begin
         sec2_in  = SECTOR_RED_YELLOW;
         frac2_in = FRAC_W'(deg_ff);
      end else if (deg_ff < DEG_W'(2 * DEG_SECTOR)) begin
         sec2_in  = SECTOR_YELLOW_GREEN;
         frac2_in = FRAC_W'(deg_ff - DEG_W'(DEG_SECTOR));
      end else if (deg_ff < DEG_W'(3 * DEG_SECTOR)) begin
         sec2_in  = SECTOR_GREEN_CYAN;
         frac2_in = FRAC_W'(deg_ff - DEG_W'(2 * DEG_SECTOR));
      end else if (deg_ff < DEG_W'(4 * DEG_SECTOR)) begin
         sec2_in  = SECTOR_CYAN_BLUE;
         frac2_in = FRAC_W'(deg_ff - DEG_W'(3 * DEG_SECTOR));
      end else if (deg_ff < DEG_W'(5 * DEG_SECTOR)) begin
         sec2_in  = SECTOR_BLUE_MAGENTA;
         frac2_in = FRAC_W'(deg_ff - DEG_W'(4 * DEG_SECTOR));
      end else begin
         sec2_in  = SECTOR_MAGENTA_RED;
         frac2_in = FRAC_W'(deg_ff - DEG_W'(5 * DEG_SECTOR));
      end
   end
   assign full2_in = FULL_W'(val1_ff) * FULL_W'(LEVEL_FULL);

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         sec2_ff  <= sec2_in;
         frac2_ff <= frac2_in;
         sat2_ff  <= sat1_ff;
         full2_ff <= full2_in;
      end
   end

   // stage 3: weights 100 - s, 6000 - s*f, 6000 - s*(60 - f)
   assign rest3  = FRAC_W'(DEG_SECTOR) - frac2_ff;
   assign cp3_in = PCT_W'(PCT_FULL) - sat2_ff;
   assign cq3_in = COEF_W'(SCALE_QT) - COEF_W'(sat2_ff) * COEF_W'(frac2_ff);
   assign ct3_in = COEF_W'(SCALE_QT) - COEF_W'(sat2_ff) * COEF_W'(rest3);

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         sec3_ff  <= sec2_ff;
         full3_ff <= full2_ff;
         cp3_ff   <= cp3_in;
         cq3_ff   <= cq3_in;
         ct3_ff   <= ct3_in;
      end
   end

   // stage 4: full scale times each weight
   assign np4_in = NP_W'(full3_ff) * NP_W'(cp3_ff);
   assign nq4_in = NQT_W'(full3_ff) * NQT_W'(cq3_ff);
   assign nt4_in = NQT_W'(full3_ff) * NQT_W'(ct3_ff);

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         sec4_ff  <= sec3_ff;
         full4_ff <= full3_ff;
         np4_ff   <= np4_in;
         nq4_ff   <= nq4_in;
         nt4_ff   <= nt4_in;
      end
   end

   // stages 5 and 6: constant dividers, sector travels alongside
   assign div_adv.est = rdy[5];
   assign div_adv.fix = rdy[6];

   always_ff @(posedge clock) begin
      if (rdy[5]) sec5_ff <= sec4_ff;
      if (rdy[6]) sec6_ff <= sec5_ff;
   end

   hsvrgb_cdiv #(.XW(FULL_W), .DIVISOR(DIV_TOP)) u_div_top (
      .clock    (clock),
      .adv      (div_adv),
      .dividend (full4_ff),
      .quotient (top_lv)
   );

   hsvrgb_cdiv #(.XW(NP_W), .DIVISOR(DIV_P)) u_div_p (
      .clock    (clock),
      .adv      (div_adv),
      .dividend (np4_ff),
      .quotient (p_lv)
   );

   hsvrgb_cdiv #(.XW(NQT_W), .DIVISOR(DIV_QT)) u_div_q (
      .clock    (clock),
      .adv      (div_adv),
      .dividend (nq4_ff),
      .quotient (q_lv)
   );

   hsvrgb_cdiv #(.XW(NQT_W), .DIVISOR(DIV_QT)) u_div_t (
      .clock    (clock),
      .adv      (div_adv),
      .dividend (nt4_ff),
      .quotient (t_lv)
   );

   // channel placement per sector
   always_comb begin
      unique case (sec6_ff)
         SECTOR_RED_YELLOW: begin
            red_in = top_lv; green_in = t_lv;   blue_in = p_lv;
         end
         SECTOR_YELLOW_GREEN: begin
            red_in = q_lv;   green_in = top_lv; blue_in = p_lv;
         end
         SECTOR_GREEN_CYAN: begin
            red_in = p_lv;   green_in = top_lv; blue_in = t_lv;
         end
         SECTOR_CYAN_BLUE: begin
            red_in = p_lv;   green_in = q_lv;   blue_in = top_lv;
         end
         SECTOR_BLUE_MAGENTA: begin
            red_in = t_lv;   green_in = p_lv;   blue_in = top_lv;
         end
         default: begin
            red_in = top_lv; green_in = p_lv;   blue_in = q_lv;
         end
      endcase
   end
   assign rsp_in = {blue_in, green_in, red_in};

   // output register
   always_ff @(posedge clock) begin
      if (out_rdy) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

// ----- rtl/core/hsvrgb_cdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_cdiv
// Two-stage divide by a constant: reciprocal estimate, then back product.
// The corrected 8-bit quotient is presented combinationally after stage two.
// ----------------------------------------------------------------------------
module hsvrgb_cdiv #(
   parameter int unsigned XW      = 28,
   parameter int unsigned DIVISOR = 600000
) (
   input  logic                           clock,
   input  hsvrgb_pkg::div_adv_type        adv,
   input  logic [XW-1:0]                  dividend,
   output logic [hsvrgb_pkg::LEVEL_W-1:0] quotient
);
   import hsvrgb_pkg::*;

   // reciprocal scaled by 2^XW, estimate never above the true quotient
   localparam int unsigned    SHIFT  = XW;
   localparam longint unsigned RECIP = (64'd1 << SHIFT) / DIVISOR;
   localparam int unsigned    RW     = $clog2(RECIP + 1);
   localparam int unsigned    PW     = XW + RW;

   logic [PW-1:0]      scaled;
   logic [LEVEL_W-1:0] est_in;
   logic [LEVEL_W-1:0] est_a_ff;
   logic [XW-1:0]      x_a_ff;
   logic [LEVEL_W-1:0] est_b_ff;
   logic [XW-1:0]      x_b_ff;
   logic [XW-1:0]      back_in;
   logic [XW-1:0]      back_ff;
   logic [XW-1:0]      diff;

   // stage one: multiply by the reciprocal
   assign scaled = PW'(dividend) * PW'(RECIP);
   assign est_in = scaled[SHIFT +: LEVEL_W];

   always_ff @(posedge clock) begin
      if (adv.est) begin
         est_a_ff <= est_in;
         x_a_ff   <= dividend;
      end
   end

   // stage two: multiply the estimate back
   assign back_in = XW'(est_a_ff) * XW'(DIVISOR);

   always_ff @(posedge clock) begin
      if (adv.fix) begin
         est_b_ff <= est_a_ff;
         x_b_ff   <= x_a_ff;
         back_ff  <= back_in;
      end
   end

   // estimate is short by at most one
   assign diff     = x_b_ff - back_ff;
   assign quotient = (diff >= XW'(DIVISOR)) ? est_b_ff + LEVEL_W'(1) : est_b_ff;

endmodule

// ----- rtl/core/hsvrgb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks of the color converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   // hue[9:0], saturation[16:10], brightness[23:17]
   input logic [hsvrgb_pkg::REQ_W-1:0] req_tdata,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   // red[7:0], green[15:8], blue[23:16]
   input logic [hsvrgb_pkg::RSP_W-1:0] rsp_tdata
);
   import hsvrgb_pkg::*;

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a moving output never stalls the input
   a_no_stall_when_draining: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req_tready low while rsp side is ready");

   // an empty output register means the pipeline can move
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low while no result is pending");

   // a stalled result is held unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (.*);
